// ===== hdl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and types for the checksummed frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int FRAME_BYTES = 4;
  localparam int CNT_W       = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int IDX_W       = 2;

  localparam logic [7:0] START_BYTE = 8'hA5;

  // control from the sequencer to the byte chain
  typedef struct packed {
    logic       shift;
    logic [7:0] din;
  } chain_ctl_t;

endpackage

// ===== hdl/sfr_ifs.sv =====
// ----------------------------------------------------------------------------
// sfr_ifs
// Valid/ready channels: received bytes in, frame results out.
// ----------------------------------------------------------------------------
interface sfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_res_if;
  logic       valid;
  logic       ready;
  logic       frame_ok;
  logic [1:0] value_index;
  logic [7:0] value_byte;
  logic       last_of_frame;

  modport source (output valid, output frame_ok, output value_index,
                  output value_byte, output last_of_frame, input ready);
  modport sink   (input valid, input frame_ok, input value_index,
                  input value_byte, input last_of_frame, output ready);
endinterface

// ===== hdl/sfr_cell.sv =====
// ----------------------------------------------------------------------------
// sfr_cell
// One byte of the payload chain; loads d_in on shift: its neighbor's byte, or the input byte at the tail.
// ----------------------------------------------------------------------------
module sfr_cell (
  input  logic                clk,
  input  sfr_pkg::chain_ctl_t ctl,
  input  logic [7:0]          d_in,
  output logic [7:0]          q
);
  import sfr_pkg::*;

  logic [7:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data_r <= d_in;
    end
  end

  assign q = data_r;

endmodule

// ===== hdl/sfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfr_ctrl
// Frame sequencer: start hunt, running sum, checksum compare, result drain.
// ----------------------------------------------------------------------------
module sfr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  sfr_byte_if.sink            in_ch,
  sfr_res_if.source           out_ch,
  input  logic [7:0]          head,
  output sfr_pkg::chain_ctl_t ctl
);
  import sfr_pkg::*;

  typedef enum logic [1:0] {
    HUNT,
    DATA,
    CSUM,
    EMIT
  } phase_t;

  phase_t             phase_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [7:0]         sum_r;
  logic               ok_r;
  logic               ov_r;
  logic               o_ok_r;
  logic [IDX_W-1:0]   o_idx_r;
  logic [7:0]         o_byte_r;
  logic               o_last_r;

  logic in_ready;
  logic in_acc;
  logic out_free;
  logic emit;
  logic cnt_last;

  assign in_ready = (phase_r != EMIT);
  assign in_acc   = in_ch.valid && in_ready;
  assign out_free = !ov_r || out_ch.ready;
  assign emit     = (phase_r == EMIT) && out_free;
  assign cnt_last = (cnt_r == CNT_W'(FRAME_BYTES - 1));

  // payload bytes shift in at the tail; during drain the head shifts out
  assign ctl.shift = (in_acc && phase_r == DATA) || (emit && ok_r);
  assign ctl.din   = in_ch.rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= HUNT;
      cnt_r    <= '0;
      sum_r    <= '0;
      ok_r     <= 1'b0;
      ov_r     <= 1'b0;
      o_ok_r   <= 1'b0;
      o_idx_r  <= '0;
      o_byte_r <= '0;
      o_last_r <= 1'b0;
    end else begin
      // during drain the EMIT arm owns the output valid
      if (ov_r && out_ch.ready && phase_r != EMIT) begin
        ov_r <= 1'b0;
      end
      unique case (phase_r)
        HUNT: begin
          if (in_acc) begin
            if (in_ch.rx_byte == START_BYTE) begin
              phase_r <= DATA;
              sum_r   <= START_BYTE;
              cnt_r   <= '0;
            end else begin
              sum_r   <= '0;
            end
          end
        end
        DATA: begin
          if (in_acc) begin
            sum_r <= sum_r + in_ch.rx_byte;
            if (cnt_last) begin
              cnt_r   <= '0;
              phase_r <= CSUM;
            end else begin
              cnt_r   <= cnt_r + 1'b1;
            end
          end
        end
        CSUM: begin
          if (in_acc) begin
            ok_r    <= (in_ch.rx_byte == sum_r);
            sum_r   <= '0;
            cnt_r   <= '0;
            phase_r <= EMIT;
          end
        end
        EMIT: begin
          if (out_free) begin
            ov_r <= 1'b1;
            if (ok_r) begin
              o_ok_r   <= 1'b1;
              o_idx_r  <= IDX_W'(cnt_r);
              o_byte_r <= head;
              o_last_r <= cnt_last;
              if (cnt_last) begin
                cnt_r   <= '0;
                phase_r <= HUNT;
              end else begin
                cnt_r   <= cnt_r + 1'b1;
              end
            end else begin
              // mismatch: single failure word
              o_ok_r   <= 1'b0;
              o_idx_r  <= '0;
              o_byte_r <= '0;
              o_last_r <= 1'b1;
              phase_r  <= HUNT;
            end
          end
        end
      endcase
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = ov_r;
  assign out_ch.frame_ok      = o_ok_r;
  assign out_ch.value_index   = o_idx_r;
  assign out_ch.value_byte    = o_byte_r;
  assign out_ch.last_of_frame = o_last_r;

  a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !o_ok_r) |-> (o_last_r && o_byte_r == 8'h00 && o_idx_r == '0))
    else $error("failure word malformed");

  a_csum_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == CSUM && in_acc) |=> (phase_r == EMIT))
    else $error("checksum word did not start drain");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (!ok_r || cnt_last)) |=> (phase_r == HUNT && ov_r && o_last_r))
    else $error("final word did not return to hunt");

  a_hunt_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == HUNT) |-> (sum_r == 8'h00 && cnt_r == '0))
    else $error("stale sum or count while hunting");

endmodule

// ===== hdl/sum_checked_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// sum_checked_frame_receiver_top
// Start-byte framed receiver with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while hunting for 0xA5, collecting the
// payload and reading the checksum byte. Payload bytes shift into a chain
// of FRAME_BYTES byte cells. After the checksum byte the input is held off
// while the chain shifts one word a cycle into the output register, unless
// the output side stalls: each payload byte on a match, a single failure
// word on a mismatch. The output register lets the next byte be taken
// while the last word of a frame still waits.
module sum_checked_frame_receiver_top (
  input  logic      clk,
  input  logic      rst_n,
  sfr_byte_if.sink  in_ch,
  sfr_res_if.source out_ch
);
  import sfr_pkg::*;

  chain_ctl_t ctl;
  logic [7:0] q [FRAME_BYTES];

  sfr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .head   (q[0]),
    .ctl    (ctl)
  );

  for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_cell
    if (k == FRAME_BYTES - 1) begin : g_tail
      sfr_cell u_cell (
        .clk  (clk),
        .ctl  (ctl),
        .d_in (ctl.din),
        .q    (q[k])
      );
    end else begin : g_body
      sfr_cell u_cell (
        .clk  (clk),
        .ctl  (ctl),
        .d_in (q[k+1]),
        .q    (q[k])
      );
    end
  end

endmodule
